// File: rtl/core/frd_pkg.sv
// ----------------------------------------------------------------------------
// frd_pkg: shared types and constants of the FASTA/FASTQ record decoder
// Holds the phase and controller codes, the result record, the command and
// status groups between controller and datapath, and the character codes.
// ----------------------------------------------------------------------------
package frd_pkg;

  // Quality window depth and its index width
  localparam int unsigned WinBytes = 20;
  localparam int unsigned WinAw    = $clog2(WinBytes + 1);

  localparam logic [15:0] MaxReadLen = 16'hFFFF;

  // Character codes
  localparam logic [7:0] ChAt    = 8'h40;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] QualOff = 8'd33;
  localparam logic [6:0] DecMax  = 7'd9;
  localparam logic [6:0] DecBase = 7'd10;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_NAME    = 3'd0,
    KIND_COMMENT = 3'd1,
    KIND_BASE    = 3'd2,
    KIND_QUAL    = 3'd3,
    KIND_KEPT    = 3'd4,
    KIND_DROPPED = 3'd5,
    KIND_SUMMARY = 3'd6,
    KIND_ERROR   = 3'd7
  } kind_e;

  // Parser phase, one-hot
  typedef enum logic [10:0] {
    PH_FIRST   = 11'b000_0000_0001,
    PH_SCAN    = 11'b000_0000_0010,
    PH_NAME    = 11'b000_0000_0100,
    PH_COMMENT = 11'b000_0000_1000,
    PH_BASES   = 11'b000_0001_0000,
    PH_PLUS    = 11'b000_0010_0000,
    PH_WINDOW  = 11'b000_0100_0000,
    PH_QUAL    = 11'b000_1000_0000,
    PH_AWAIT   = 11'b001_0000_0000,
    PH_DONE    = 11'b010_0000_0000,
    PH_ERROR   = 11'b100_0000_0000
  } phase_e;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b00_0001,
    ST_FEED    = 6'b00_0010,
    ST_REPLAY  = 6'b00_0100,
    ST_ZERO    = 6'b00_1000,
    ST_SUMMARY = 6'b01_0000,
    ST_FLUSH   = 6'b10_0000
  } ctrl_state_e;

  // Byte source of one parser step
  typedef enum logic [1:0] {
    SRC_INPUT  = 2'd0,
    SRC_REPLAY = 2'd1,
    SRC_ZERO   = 2'd2
  } src_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [23:0] record_index;
    logic [15:0] item_count;
    logic [39:0] total_bases;
    logic        last;
  } res_t;

  typedef struct packed {
    logic load;
    logic feed;
    src_e src;
    logic summary;
  } dp_cmd_t;

  typedef struct packed {
    logic retry;
    logic replay_pending;
    logic active;
    logic eod;
  } dp_status_t;

endpackage

// File: rtl/core/frd_ctrl.sv
// ----------------------------------------------------------------------------
// frd_ctrl: request sequencer of the record decoder
// Steps the datapath through the request byte, window replays, the closing
// zero bytes at end of data, the summary and the final result flush.
// ----------------------------------------------------------------------------
module frd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                room_i,
  input  frd_pkg::dp_status_t st_i,
  output frd_pkg::dp_cmd_t    cmd_o,
  output logic                flush_o
);

  frd_pkg::ctrl_state_e state_q, state_d;
  logic [2:0] zc_q, zc_d;

  assign in_stall_o = (state_q != frd_pkg::ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    zc_d          = zc_q;
    cmd_o         = '0;
    cmd_o.src     = frd_pkg::SRC_INPUT;
    flush_o       = 1'b0;
    case (state_q)
      frd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          zc_d       = '0;
          state_d    = frd_pkg::ST_FEED;
        end
      end
      frd_pkg::ST_FEED: begin
        if (room_i) begin
          cmd_o.feed = 1'b1;
          cmd_o.src  = frd_pkg::SRC_INPUT;
          if (!st_i.retry) state_d = frd_pkg::ST_REPLAY;
        end
      end
      frd_pkg::ST_REPLAY: begin
        if (st_i.replay_pending) begin
          if (room_i) begin
            cmd_o.feed = 1'b1;
            cmd_o.src  = frd_pkg::SRC_REPLAY;
          end
        end else if (st_i.eod) begin
          state_d = frd_pkg::ST_ZERO;
        end else begin
          state_d = frd_pkg::ST_FLUSH;
        end
      end
      frd_pkg::ST_ZERO: begin
        if (zc_q == 3'd4 || !st_i.active) begin
          state_d = frd_pkg::ST_SUMMARY;
        end else if (room_i) begin
          cmd_o.feed = 1'b1;
          cmd_o.src  = frd_pkg::SRC_ZERO;
          if (!st_i.retry) begin
            zc_d    = zc_q + 3'd1;
            state_d = frd_pkg::ST_REPLAY;
          end
        end
      end
      frd_pkg::ST_SUMMARY: begin
        if (room_i) begin
          cmd_o.summary = 1'b1;
          state_d       = frd_pkg::ST_FLUSH;
        end
      end
      frd_pkg::ST_FLUSH: begin
        if (room_i) begin
          flush_o = 1'b1;
          state_d = frd_pkg::ST_IDLE;
        end
      end
      default: state_d = frd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frd_pkg::ST_IDLE;
      zc_q    <= '0;
    end else begin
      state_q <= state_d;
      zc_q    <= zc_d;
    end
  end

endmodule

// File: rtl/core/frd_dp.sv
// ----------------------------------------------------------------------------
// frd_dp: parser datapath of the record decoder
// Holds the parser phase, counters, quality window and configuration, and
// runs one parser step per feed command, giving at most one result.
// ----------------------------------------------------------------------------
module frd_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  frd_pkg::dp_cmd_t    cmd_i,
  output frd_pkg::dp_status_t st_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_data_i,
  input  logic                cfg_we_i,
  input  logic [23:0]         cfg_data_i,
  output logic                emit_o,
  output frd_pkg::res_t       res_o
);

  localparam int unsigned Aw = frd_pkg::WinAw;
  localparam logic [Aw:0] WinW = (Aw + 1)'(frd_pkg::WinBytes);

  frd_pkg::phase_e phase_q, phase_d;
  logic        fastq_q, fastq_d;
  logic        numq_q, numq_d;
  logic [7:0]  prev_q, prev_d;
  logic [15:0] bcnt_q, bcnt_d;
  logic [15:0] qcnt_q, qcnt_d;
  logic [6:0]  acc_q, acc_d;
  logic        dseen_q, dseen_d;
  logic [Aw-1:0] wfill_q, wfill_d;
  logic [Aw-1:0] wbase_q, wbase_d;
  logic [Aw-1:0] rdptr_q, rdptr_d;
  logic [Aw-1:0] rem_q, rem_d;
  logic [23:0] rcnt_q, rcnt_d;
  logic [39:0] total_q, total_d;
  logic [23:0] expect_q;
  logic [7:0]  byte_q;
  logic        eod_q;
  logic [7:0]  win_q [frd_pkg::WinBytes];

  logic          retry;
  logic          win_we;
  logic [Aw-1:0] win_wa;
  logic [7:0]    win_wd;

  // Add two window positions modulo the window depth
  function automatic logic [Aw-1:0] wrap_add(input logic [Aw-1:0] a, input logic [Aw-1:0] b);
    logic [Aw:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= WinW) s = s - WinW;
    return s[Aw-1:0];
  endfunction

  assign st_o.retry          = retry;
  assign st_o.replay_pending = (rem_q != '0);
  assign st_o.active         = |(phase_q & (frd_pkg::PH_NAME | frd_pkg::PH_COMMENT |
                                  frd_pkg::PH_BASES | frd_pkg::PH_PLUS |
                                  frd_pkg::PH_WINDOW | frd_pkg::PH_QUAL |
                                  frd_pkg::PH_AWAIT));
  assign st_o.eod            = eod_q;

  // One parser step
  always_comb begin
    logic [7:0]    b;
    logic          do_finish, do_close, keep, do_scan, drain, is_nl;
    logic [Aw-1:0] rem_after, fill_n;

    phase_d = phase_q;  fastq_d = fastq_q;  numq_d = numq_q;  prev_d = prev_q;
    bcnt_d  = bcnt_q;   qcnt_d  = qcnt_q;   acc_d  = acc_q;   dseen_d = dseen_q;
    wfill_d = wfill_q;  wbase_d = wbase_q;  rdptr_d = rdptr_q; rem_d = rem_q;
    rcnt_d  = rcnt_q;   total_d = total_q;
    retry   = 1'b0;
    win_we  = 1'b0;
    win_wa  = wrap_add(wbase_q, wfill_q);
    emit_o  = 1'b0;
    res_o   = '0;
    do_finish = 1'b0; do_close = 1'b0; keep = 1'b0; do_scan = 1'b0; drain = 1'b0;
    fill_n  = wfill_q;

    case (cmd_i.src)
      frd_pkg::SRC_INPUT:  b = byte_q;
      frd_pkg::SRC_REPLAY: b = win_q[rdptr_q];
      default:             b = frd_pkg::ChNul;
    endcase
    win_wd    = b;
    is_nl     = (b == frd_pkg::ChNl) || (b == frd_pkg::ChNul);
    rem_after = (cmd_i.src == frd_pkg::SRC_REPLAY) ? rem_q - Aw'(1) : '0;

    if (cmd_i.feed) begin
      prev_d = b;
      case (phase_q)
        frd_pkg::PH_FIRST: begin
          if (b == frd_pkg::ChAt || b == frd_pkg::ChGt) begin
            fastq_d = (b == frd_pkg::ChAt);
            phase_d = frd_pkg::PH_SCAN;
            do_scan = 1'b1;
          end else begin
            emit_o       = 1'b1;
            res_o.kind   = frd_pkg::KIND_ERROR;
            res_o.value  = b;
            phase_d      = frd_pkg::PH_ERROR;
          end
        end
        frd_pkg::PH_SCAN: do_scan = 1'b1;
        frd_pkg::PH_NAME: begin
          if (b == frd_pkg::ChSp || b == frd_pkg::ChTab) begin
            phase_d = frd_pkg::PH_COMMENT;
          end else if (is_nl) begin
            phase_d = frd_pkg::PH_BASES;
          end else begin
            emit_o             = 1'b1;
            res_o.kind         = frd_pkg::KIND_NAME;
            res_o.value        = b;
            res_o.record_index = rcnt_q;
          end
        end
        frd_pkg::PH_COMMENT: begin
          if (is_nl) begin
            phase_d = frd_pkg::PH_BASES;
          end else begin
            emit_o             = 1'b1;
            res_o.kind         = frd_pkg::KIND_COMMENT;
            res_o.value        = b;
            res_o.record_index = rcnt_q;
          end
        end
        frd_pkg::PH_BASES: begin
          if (b == frd_pkg::ChNul ||
              ((b == frd_pkg::ChPlus || b == frd_pkg::ChGt) && prev_q == frd_pkg::ChNl)) begin
            if (!fastq_q) begin
              do_close = 1'b1;
              keep     = 1'b1;
              do_scan  = 1'b1;
            end else if (b == frd_pkg::ChPlus) begin
              phase_d = frd_pkg::PH_PLUS;
            end else begin
              qcnt_d    = '0;
              do_finish = 1'b1;
            end
          end else if (b != frd_pkg::ChNl) begin
            emit_o             = 1'b1;
            res_o.kind         = frd_pkg::KIND_BASE;
            res_o.value        = b;
            res_o.record_index = rcnt_q;
            if (bcnt_q < frd_pkg::MaxReadLen) bcnt_d = bcnt_q + 16'd1;
          end
        end
        frd_pkg::PH_PLUS: begin
          if (is_nl) begin
            phase_d = frd_pkg::PH_WINDOW;
            wfill_d = '0;
            wbase_d = (cmd_i.src == frd_pkg::SRC_REPLAY) ? wrap_add(rdptr_q, Aw'(1)) : '0;
          end
        end
        frd_pkg::PH_WINDOW: begin
          // Window bytes leave the previous byte untouched
          prev_d = prev_q;
          if ({1'b0, wfill_q} < WinW) begin
            win_we = 1'b1;
            fill_n = wfill_q + Aw'(1);
          end
          wfill_d = fill_n;
          if (b == frd_pkg::ChSp) begin
            numq_d = 1'b1;
            drain  = 1'b1;
          end else if (b == frd_pkg::ChNul || {1'b0, fill_n} >= WinW) begin
            numq_d = 1'b0;
            drain  = 1'b1;
          end
        end
        frd_pkg::PH_QUAL: begin
          if (is_nl || qcnt_q >= bcnt_q) begin
            if (numq_q && dseen_q && qcnt_q < bcnt_q) begin
              // Emit the pending decimal, then take the same byte again
              retry              = 1'b1;
              prev_d             = prev_q;
              emit_o             = 1'b1;
              res_o.kind         = frd_pkg::KIND_QUAL;
              res_o.value        = {1'b0, acc_q};
              res_o.record_index = rcnt_q;
              qcnt_d             = qcnt_q + 16'd1;
              dseen_d            = 1'b0;
              acc_d              = '0;
            end else begin
              do_finish = 1'b1;
            end
          end else if (numq_q) begin
            if (b >= frd_pkg::ChZero && b <= frd_pkg::ChNine) begin
              if (acc_q <= frd_pkg::DecMax) begin
                acc_d   = 7'(acc_q * frd_pkg::DecBase) + 7'(b - frd_pkg::ChZero);
                dseen_d = 1'b1;
              end
            end else if (dseen_q) begin
              emit_o             = 1'b1;
              res_o.kind         = frd_pkg::KIND_QUAL;
              res_o.value        = {1'b0, acc_q};
              res_o.record_index = rcnt_q;
              qcnt_d             = qcnt_q + 16'd1;
              acc_d              = '0;
              dseen_d            = 1'b0;
            end
          end else begin
            emit_o             = 1'b1;
            res_o.kind         = frd_pkg::KIND_QUAL;
            res_o.value        = b - frd_pkg::QualOff;
            res_o.record_index = rcnt_q;
            qcnt_d             = qcnt_q + 16'd1;
          end
        end
        frd_pkg::PH_AWAIT: begin
          do_close = 1'b1;
          keep     = (b == frd_pkg::ChAt);
          do_scan  = 1'b1;
        end
        default: ;
      endcase

      // Close a FASTQ record after its quality line, or at a '>' or zero byte in its bases
      if (do_finish) begin
        if (({1'b0, rcnt_q} + 25'd1) >= {1'b0, expect_q}) begin
          do_close = 1'b1;
          keep     = 1'b1;
          do_scan  = 1'b1;
        end else if (b == frd_pkg::ChNl) begin
          phase_d = frd_pkg::PH_AWAIT;
        end else begin
          do_close = 1'b1;
          do_scan  = 1'b1;
        end
      end

      if (do_close) begin
        emit_o             = 1'b1;
        res_o.record_index = rcnt_q;
        if (keep) begin
          total_d          = total_q + {24'd0, bcnt_q};
          res_o.kind       = frd_pkg::KIND_KEPT;
          res_o.item_count = bcnt_q;
          rcnt_d           = rcnt_q + 24'd1;
        end else begin
          res_o.kind       = frd_pkg::KIND_DROPPED;
          res_o.item_count = qcnt_d;
        end
        phase_d = frd_pkg::PH_SCAN;
      end

      // Look for the next record start
      if (do_scan && (b == frd_pkg::ChAt || b == frd_pkg::ChGt) && prev_q == frd_pkg::ChNl) begin
        if (rcnt_d >= expect_q) begin
          phase_d = frd_pkg::PH_DONE;
        end else begin
          phase_d = frd_pkg::PH_NAME;
          bcnt_d  = '0;
          qcnt_d  = '0;
        end
      end

      // Advance the replay, or restart it over the fresh window
      if (drain) begin
        wfill_d = '0;
        phase_d = frd_pkg::PH_QUAL;
        qcnt_d  = '0;
        acc_d   = '0;
        dseen_d = 1'b0;
        rdptr_d = wbase_q;
        rem_d   = fill_n + rem_after;
      end else if (cmd_i.src == frd_pkg::SRC_REPLAY && !retry) begin
        rdptr_d = wrap_add(rdptr_q, Aw'(1));
        rem_d   = rem_after;
      end
    end

    // Summary, then return to the reset state
    if (cmd_i.summary) begin
      emit_o             = (phase_q != frd_pkg::PH_ERROR);
      res_o.kind         = frd_pkg::KIND_SUMMARY;
      res_o.record_index = rcnt_q;
      phase_d = frd_pkg::PH_FIRST;  fastq_d = 1'b0;  numq_d = 1'b0;
      prev_d  = frd_pkg::ChNl;      bcnt_d = '0;     qcnt_d = '0;
      acc_d   = '0;  dseen_d = 1'b0;  wfill_d = '0;  rcnt_d = '0;  total_d = '0;
    end

    // The summary reports the total reached before the state returns to reset
    res_o.total_bases = cmd_i.summary ? total_q : total_d;
  end

  // Control and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= frd_pkg::PH_FIRST;
      fastq_q  <= 1'b0;
      numq_q   <= 1'b0;
      prev_q   <= frd_pkg::ChNl;
      bcnt_q   <= '0;
      qcnt_q   <= '0;
      acc_q    <= '0;
      dseen_q  <= 1'b0;
      wfill_q  <= '0;
      wbase_q  <= '0;
      rdptr_q  <= '0;
      rem_q    <= '0;
      rcnt_q   <= '0;
      total_q  <= '0;
      expect_q <= '0;
      eod_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fastq_q <= fastq_d;
      numq_q  <= numq_d;
      prev_q  <= prev_d;
      bcnt_q  <= bcnt_d;
      qcnt_q  <= qcnt_d;
      acc_q   <= acc_d;
      dseen_q <= dseen_d;
      wfill_q <= wfill_d;
      wbase_q <= wbase_d;
      rdptr_q <= rdptr_d;
      rem_q   <= rem_d;
      rcnt_q  <= rcnt_d;
      total_q <= total_d;
      if (cfg_we_i) expect_q <= cfg_data_i;
      if (cmd_i.load) eod_q <= end_of_data_i;
    end
  end

  // Request byte and quality window payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) byte_q <= data_byte_i;
    if (cmd_i.feed && win_we) win_q[win_wa] <= win_wd;
  end

endmodule

// File: rtl/core/frd_out.sv
// ----------------------------------------------------------------------------
// frd_out: result buffer of the record decoder
// Holds the newest result back until the next one or the end of the request
// is known, so that the final result can carry its last flag.
// ----------------------------------------------------------------------------
module frd_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          emit_i,
  input  frd_pkg::res_t res_i,
  input  logic          flush_i,
  output logic          room_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output frd_pkg::res_t out_o
);

  logic          pend_vld_q, pend_vld_d;
  frd_pkg::res_t pend_q;
  logic          out_vld_q, out_vld_d;
  frd_pkg::res_t out_q;
  frd_pkg::res_t move_res;
  logic          move;

  assign room_o      = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;
  assign move        = pend_vld_q && (emit_i || flush_i);

  always_comb begin
    out_vld_d     = (out_vld_q && out_stall_i) || move;
    pend_vld_d    = emit_i || (pend_vld_q && !flush_i);
    move_res      = pend_q;
    move_res.last = flush_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Advance pending result to the output register
  always_ff @(posedge clk_i) begin
    if (move) out_q <= move_res;
    if (emit_i) pend_q <= res_i;
  end

endmodule

// File: rtl/core/fastq_record_decoder.sv
// ----------------------------------------------------------------------------
// fastq_record_decoder: FASTA/FASTQ byte stream to record results
// Decodes names, comments, bases and qualities and closes each record as
// kept or discarded, with a summary at the end of the data.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one file byte per request with an end-of-data
//   flag; in_stall_o is high while a request is being worked on. Results
//   leave on the output channel, one per transfer, the final one of each
//   request with last_o set. The expected record count is written on the
//   configuration channel between requests; cfg_ready_o is always high.
//   A plain byte goes from acceptance to the next acceptance through the
//   accepting step, one parse step, one replay check and one flush.
//   A quality window that closes replays its up to 20 stored bytes, one
//   parse step per cycle while the output has room; a decimal quality
//   closed by a line end takes its byte twice. At end of data each
//   closing zero byte (up to 4) is a parse step and a replay check.
//   Each result is held one stage and leaves with the next result; the
//   final one leaves with the flush. Reset clears all parser state and
//   the expected count; the window store needs no clearing. A stalled
//   receiver holds the output register and the parser waits before each
//   parse step, the summary and the flush.
// ----------------------------------------------------------------------------
module fastq_record_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_data_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] expected_records_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  value_o,
  output logic [23:0] record_index_o,
  output logic [15:0] item_count_o,
  output logic [39:0] total_bases_o,
  output logic        last_o
);

  frd_pkg::dp_cmd_t    cmd;
  frd_pkg::dp_status_t st;
  frd_pkg::res_t       res;
  frd_pkg::res_t       out;
  logic                emit;
  logic                room;
  logic                flush;

  assign cfg_ready_o = 1'b1;

  frd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .room_i     (room),
    .st_i       (st),
    .cmd_o      (cmd),
    .flush_o    (flush)
  );

  frd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .data_byte_i   (data_byte_i),
    .end_of_data_i (end_of_data_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (expected_records_i),
    .emit_o        (emit),
    .res_o         (res)
  );

  frd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .res_i       (res),
    .flush_i     (flush),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out)
  );

  assign kind_o         = out.kind;
  assign value_o        = out.value;
  assign record_index_o = out.record_index;
  assign item_count_o   = out.item_count;
  assign total_bases_o  = out.total_bases;
  assign last_o         = out.last;

endmodule
